FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property with an antecedent, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pps_pkg.sv
// Package with constants and types of the pulse period speedometer.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int unsigned SPEED_NUM   = 1800000;
    localparam int unsigned SPEED_MAX   = 250;
    localparam int unsigned MM_PER_M    = 1000;
    localparam int unsigned STALL_LIMIT = 10;

    localparam int unsigned M_SHIFT = 26;
    localparam int unsigned M_RECIP = ((32'd1 << M_SHIFT) + MM_PER_M - 1) / MM_PER_M;

    localparam logic [15:0] CIRC_RESET   = 16'd2000;
    localparam logic [7:0]  PULSES_RESET = 8'd1;

    localparam logic REG_CIRC   = 1'b0;
    localparam logic REG_PULSES = 1'b1;

    typedef enum logic [1:0] {
        OP_CAPTURE  = 2'd0,
        OP_OVERFLOW = 2'd1,
        OP_TICK     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPD,
        ST_DIV_A,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/pulse_period_speedometer.sv
// Top level of the pulse period speedometer with its shared serial divider.
//
// Channel   Direction  Handshake           Content
// s_axis    in         s_tvalid/s_tready   tuser: operation, tdata: capture fields
// m_axis    out        m_tvalid/m_tready   tdata: speed, max speed, odometer, trip
// apb       in         psel/penable/pready wheel circumference, pulses per turn
//
// A tick uses one restoring divider, which gives one quotient bit per cycle
// and runs 21 steps for the speed and 16 steps for the distance.
// The distance quotient is scaled to meters by a reciprocal multiplication.
// Reset is synchronous; after it the block is ready in the next cycle.
// A held result stalls the next tick in ST_FINISH; until that tick comes, captures still go on.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_period_speedometer
    import pps_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] capture_value, [16] overflow_pending, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] speed_kmh, [15:8] max_speed_kmh,
                                   // [47:16] odometer_m, [79:48] trip_m
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CAP_KEEP = (TIMER_BITS < 16) ? TIMER_BITS : 16;
    localparam logic [15:0] CAP_MASK = 16'((33'h1 << CAP_KEEP) - 33'h1);
    localparam logic [32:0] CAP_HALF = 33'h1 << (TIMER_BITS - 1);
    localparam int SPD_STEPS = $clog2(SPEED_NUM + 1);
    localparam logic [31:0] SPD_DVD = 32'(SPEED_NUM) << (32 - SPD_STEPS);
    localparam logic [4:0] SPD_CNT = 5'(SPD_STEPS);
    localparam logic [4:0] DIST_CNT = 5'd16;
    localparam logic [16:0] DIST_RECIP = 17'(M_RECIP);

    state_t state_reg, state_next;

    logic [15:0] circ_reg;
    logic [7:0]  pulses_reg;
    logic [15:0] last_cap_reg;
    logic [15:0] ovf_reg;
    logic [31:0] period_reg;
    logic        fresh_reg;
    logic [3:0]  stall_reg;
    logic [7:0]  speed_reg;
    logic [7:0]  max_reg;
    logic [31:0] odo_reg;
    logic [31:0] trip_reg;
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;

    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg;
    logic [31:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg;

    logic        s_fire;
    op_t         op;
    logic [15:0] cap_m;
    logic        ovf_inc;
    logic [15:0] ovf_eff;
    logic [47:0] ovf_sh;
    logic [31:0] period_new;
    logic [31:0] per;
    logic        do_speed;
    logic        spd_path;
    logic        has_pulses;
    logic        div_done;
    logic        out_free;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [7:0]  spd_q;
    logic [3:0]  stall_inc;
    logic [7:0]  speed_fin;
    logic        cfg_wr;
    logic [32:0] dist_prod;
    logic [31:0] dist_m;

    logic        div_start;
    logic [31:0] div_dvd;
    logic [31:0] div_dvs;
    logic [4:0]  div_steps;
    logic        spd_load;
    logic [7:0]  spd_value;
    logic        odo_add;
    logic        fin;

    assign op         = op_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign has_pulses = (pulses_reg != 8'd0);
    assign div_done   = (cnt_reg == 5'd0);

    assign cap_m      = s_tdata[15:0] & CAP_MASK;
    assign ovf_inc    = s_tdata[16] && ({17'b0, cap_m} < CAP_HALF) && (ovf_reg != 16'hFFFF);
    assign ovf_eff    = ovf_reg + {15'b0, ovf_inc};
    assign ovf_sh     = {32'b0, ovf_eff} << TIMER_BITS;
    assign period_new = ovf_sh[31:0] + {16'b0, cap_m} - {16'b0, last_cap_reg};

    assign per      = {period_reg[28:0], 3'b000};
    assign do_speed = fresh_reg && (period_reg != 32'd0);
    assign spd_path = do_speed && (per != 32'd0);

    assign rem_sh   = {rem_reg, dvd_reg[31]};
    assign rem_ge   = (rem_sh >= {1'b0, dvs_reg});
    assign rem_next = rem_ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
    assign dvd_next = {dvd_reg[30:0], rem_ge};

    assign dist_prod = {17'b0, dvd_reg[15:0]} * {16'b0, DIST_RECIP};
    assign dist_m    = 32'(dist_prod >> M_SHIFT);

    assign spd_q     = (dvd_reg > 32'(SPEED_MAX)) ? 8'd0 : dvd_reg[7:0];
    assign stall_inc = (stall_reg < 4'(STALL_LIMIT)) ? stall_reg + 4'd1 : stall_reg;
    assign speed_fin = (stall_inc >= 4'(STALL_LIMIT)) ? 8'd0 : speed_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && op == OP_TICK) begin
                    if (spd_path) begin
                        state_next = ST_SPD;
                    end else if (do_speed && has_pulses) begin
                        state_next = ST_DIV_A;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SPD: begin
                if (div_done) begin
                    state_next = has_pulses ? ST_DIV_A : ST_FINISH;
                end
            end
            ST_DIV_A: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = 32'd0;
        div_dvs   = 32'd0;
        div_steps = 5'd0;
        spd_load  = 1'b0;
        spd_value = 8'd0;
        odo_add   = 1'b0;
        fin       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && op == OP_TICK) begin
                    if (spd_path) begin
                        div_start = 1'b1;
                        div_dvd   = SPD_DVD;
                        div_dvs   = per;
                        div_steps = SPD_CNT;
                    end else if (do_speed) begin
                        spd_load = 1'b1;
                        if (has_pulses) begin
                            div_start = 1'b1;
                            div_dvd   = {circ_reg, 16'b0};
                            div_dvs   = {24'b0, pulses_reg};
                            div_steps = DIST_CNT;
                        end
                    end
                end
            end
            ST_SPD: begin
                if (div_done) begin
                    spd_load  = 1'b1;
                    spd_value = spd_q;
                    if (has_pulses) begin
                        div_start = 1'b1;
                        div_dvd   = {circ_reg, 16'b0};
                        div_dvs   = {24'b0, pulses_reg};
                        div_steps = DIST_CNT;
                    end
                end
            end
            ST_DIV_A: begin
                odo_add = div_done;
            end
            ST_FINISH: begin
                fin = out_free;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            circ_reg     <= CIRC_RESET;
            pulses_reg   <= PULSES_RESET;
            last_cap_reg <= 16'd0;
            ovf_reg      <= 16'd0;
            period_reg   <= 32'd0;
            fresh_reg    <= 1'b0;
            stall_reg    <= 4'd0;
            speed_reg    <= 8'd0;
            max_reg      <= 8'd0;
            odo_reg      <= 32'd0;
            trip_reg     <= 32'd0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 5'd0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                if (paddr[2] == REG_CIRC) begin
                    circ_reg <= pwdata[15:0];
                end else begin
                    pulses_reg <= pwdata[7:0];
                end
            end

            if (s_fire) begin
                case (op)
                    OP_CAPTURE: begin
                        last_cap_reg <= cap_m;
                        ovf_reg      <= 16'd0;
                        period_reg   <= period_new;
                        fresh_reg    <= 1'b1;
                        stall_reg    <= 4'd0;
                    end
                    OP_OVERFLOW: begin
                        if (ovf_reg != 16'hFFFF) begin
                            ovf_reg <= ovf_reg + 16'd1;
                        end
                    end
                    OP_TICK: begin
                        fresh_reg <= 1'b0;
                    end
                    default: begin
                        fresh_reg <= fresh_reg;
                    end
                endcase
            end

            if (div_start) begin
                cnt_reg <= div_steps;
            end else if (!div_done) begin
                cnt_reg <= cnt_reg - 5'd1;
            end

            if (spd_load) begin
                speed_reg <= spd_value;
                if (spd_value > max_reg) begin
                    max_reg <= spd_value;
                end
            end

            if (odo_add) begin
                odo_reg  <= odo_reg + dist_m;
                trip_reg <= trip_reg + dist_m;
            end

            if (fin) begin
                stall_reg    <= stall_inc;
                speed_reg    <= speed_fin;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dvd_reg <= div_dvd;
            dvs_reg <= div_dvs;
            rem_reg <= 32'd0;
        end else if (!div_done) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (fin) begin
            m_tdata_reg <= {trip_reg, odo_reg, max_reg, speed_fin};
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CIRC:   prdata = {16'b0, circ_reg};
            REG_PULSES: prdata = {24'b0, pulses_reg};
            default:    prdata = 32'd0;
        endcase
    end

    `ASSERT_IMPLIES(a_div_in_div_state, cnt_reg != 5'd0,
        state_reg == ST_SPD || state_reg == ST_DIV_A,
        "Divider runs outside a divide state.")
    `ASSERT_ALWAYS(a_stall_limit, stall_reg <= 4'(STALL_LIMIT), "Stall count passed its limit.")
    `ASSERT_IMPLIES(a_speed_range, m_tvalid_reg, m_tdata_reg[7:0] <= 8'(SPEED_MAX),
        "Reported speed above the limit.")
    `ASSERT_IMPLIES(a_speed_below_max, m_tvalid_reg, m_tdata_reg[7:0] <= m_tdata_reg[15:8],
        "Reported speed above the reported maximum.")

endmodule
